### hw/rtl/pslab_pkg.sv
// ---------------------------------------------------------------------------
// pslab_pkg
// Shared types, codes and constants of the page slab first-fit allocator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pslab_pkg;

  // field widths
  localparam int ACT_W      = 2;
  localparam int BYTES_W    = 32;
  localparam int TSLAB_W    = 3;
  localparam int PAGE_W     = 16;
  localparam int STAT_W     = 3;
  localparam int PB_W       = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // actions
  localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NONE  = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK           = 3'd0;
  localparam logic [STAT_W-1:0] STAT_TOO_BIG      = 3'd1;
  localparam logic [STAT_W-1:0] STAT_NO_SPACE     = 3'd2;
  localparam logic [STAT_W-1:0] STAT_FREE_UNKNOWN = 3'd3;
  localparam logic [STAT_W-1:0] STAT_TABLE_FULL   = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_MAX   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLAB_MAX   = 2'd2;

  // configuration reset values
  localparam logic [PB_W-1:0]   PAGE_BYTES_RST = 17'd512;
  localparam logic [PAGE_W-1:0] POOL_MAX_RST   = 16'd65535;
  localparam logic [PAGE_W-1:0] SLAB_MAX_RST   = 16'd8192;

  // one segment table entry
  typedef struct packed {
    logic              used;
    logic [PAGE_W-1:0] start;
    logic [PAGE_W-1:0] len;
  } seg_entry_t;

  // datapath commands
  typedef logic [4:0] cmd_op_t;
  localparam cmd_op_t CMD_NONE      = 5'd0;
  localparam cmd_op_t CMD_LOAD      = 5'd1;
  localparam cmd_op_t CMD_DIV_STEP  = 5'd2;
  localparam cmd_op_t CMD_SCAN_RD   = 5'd3;
  localparam cmd_op_t CMD_SCAN_NEXT = 5'd4;
  localparam cmd_op_t CMD_HIT       = 5'd5;
  localparam cmd_op_t CMD_GRANT     = 5'd6;
  localparam cmd_op_t CMD_UP_RD     = 5'd7;
  localparam cmd_op_t CMD_UP_WR     = 5'd8;
  localparam cmd_op_t CMD_INSERT    = 5'd9;
  localparam cmd_op_t CMD_NX_RD     = 5'd10;
  localparam cmd_op_t CMD_NX_CHK    = 5'd11;
  localparam cmd_op_t CMD_FREE_WR   = 5'd12;
  localparam cmd_op_t CMD_DN_RD     = 5'd13;
  localparam cmd_op_t CMD_DN_WR     = 5'd14;
  localparam cmd_op_t CMD_DN_FIN    = 5'd15;
  localparam cmd_op_t CMD_NSS       = 5'd16;
  localparam cmd_op_t CMD_OPEN      = 5'd17;
  localparam cmd_op_t CMD_OPEN_REST = 5'd18;
  localparam cmd_op_t CMD_CLEAR     = 5'd19;
  localparam cmd_op_t CMD_FAIL      = 5'd20;
  localparam cmd_op_t CMD_FINISH    = 5'd21;

  typedef struct packed {
    cmd_op_t           op;
    logic [STAT_W-1:0] code;
  } dp_cmd_t;

  typedef struct packed {
    logic act_alloc;
    logic act_free;
    logic act_clear;
    logic tslab_bad;
    logic div_done;
    logic req_too_big;
    logic scan_end;
    logic hit;
    logic split;
    logic seg_full;
    logic up_more;
    logic nx_exists;
    logic dn_more;
    logic pool_full;
    logic new_too_big;
    logic no_slot;
    logic open_excess;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

### hw/rtl/pslab_req_if.sv
// ---------------------------------------------------------------------------
// pslab_req_if
// Request channel: valid/ready handshake with one request item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pslab_req_if;
  import pslab_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ACT_W-1:0]     action;
  logic [BYTES_W-1:0]   request_bytes;
  logic [TSLAB_W-1:0]   target_slab;
  logic [PAGE_W-1:0]    target_start_page;

  modport source (output valid, action, request_bytes, target_slab, target_start_page,
                  input ready);
  modport sink (input valid, action, request_bytes, target_slab, target_start_page,
                output ready);
endinterface

`default_nettype wire

### hw/rtl/pslab_rsp_if.sv
// ---------------------------------------------------------------------------
// pslab_rsp_if
// Response channel: valid/ready handshake with one result item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pslab_rsp_if;
  import pslab_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STAT_W-1:0]    status;
  logic [TSLAB_W-1:0]   grant_slab;
  logic [PAGE_W-1:0]    grant_start_page;
  logic [PAGE_W-1:0]    grant_pages;
  logic [PAGE_W-1:0]    pool_pages_used;

  modport source (output valid, status, grant_slab, grant_start_page, grant_pages,
                  pool_pages_used, input ready);
  modport sink (input valid, status, grant_slab, grant_start_page, grant_pages,
                pool_pages_used, output ready);
endinterface

`default_nettype wire

### hw/rtl/pslab_ram.sv
// ---------------------------------------------------------------------------
// pslab_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pslab_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 256
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

`default_nettype wire

### hw/rtl/pslab_ctrl.sv
// ---------------------------------------------------------------------------
// pslab_ctrl
// Sequencer: steps the datapath through divide, scan, split, merge and
// slab open for one request item at a time.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pslab_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  req_valid,
  output      logic                  req_ready,
  input  wire pslab_pkg::dp_status_t sts,
  output      pslab_pkg::dp_cmd_t    cmd
);
  import pslab_pkg::*;

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_DEC    = 5'd1;
  localparam logic [4:0] ST_DIV    = 5'd2;
  localparam logic [4:0] ST_DCHK   = 5'd3;
  localparam logic [4:0] ST_SRD    = 5'd4;
  localparam logic [4:0] ST_SCHK   = 5'd5;
  localparam logic [4:0] ST_AHIT   = 5'd6;
  localparam logic [4:0] ST_UPCHK  = 5'd7;
  localparam logic [4:0] ST_UPWR   = 5'd8;
  localparam logic [4:0] ST_FHIT   = 5'd9;
  localparam logic [4:0] ST_NXCHK  = 5'd10;
  localparam logic [4:0] ST_FWR    = 5'd11;
  localparam logic [4:0] ST_DNCHK  = 5'd12;
  localparam logic [4:0] ST_DNWR   = 5'd13;
  localparam logic [4:0] ST_MISS   = 5'd14;
  localparam logic [4:0] ST_OPEN   = 5'd15;
  localparam logic [4:0] ST_OREST  = 5'd16;
  localparam logic [4:0] ST_FINISH = 5'd17;

  logic [4:0] state;
  logic [4:0] state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and command
  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd.op     = CMD_NONE;
    cmd.code   = STAT_OK;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.op     = CMD_LOAD;
          state_next = ST_DEC;
        end
      end
      ST_DEC: begin
        if (sts.act_alloc) begin
          state_next = ST_DIV;
        end else if (sts.act_free) begin
          if (sts.tslab_bad) begin
            cmd.op     = CMD_FAIL;
            cmd.code   = STAT_FREE_UNKNOWN;
            state_next = ST_FINISH;
          end else begin
            state_next = ST_SRD;
          end
        end else if (sts.act_clear) begin
          cmd.op     = CMD_CLEAR;
          state_next = ST_FINISH;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_next = ST_DCHK;
        end else begin
          cmd.op = CMD_DIV_STEP;
        end
      end
      ST_DCHK: begin
        if (sts.req_too_big) begin
          cmd.op     = CMD_FAIL;
          cmd.code   = STAT_TOO_BIG;
          state_next = ST_FINISH;
        end else begin
          state_next = ST_SRD;
        end
      end
      // segment scan: read, then check
      ST_SRD: begin
        if (sts.scan_end) begin
          if (sts.act_alloc) begin
            state_next = ST_MISS;
          end else begin
            cmd.op     = CMD_FAIL;
            cmd.code   = STAT_FREE_UNKNOWN;
            state_next = ST_FINISH;
          end
        end else begin
          cmd.op     = CMD_SCAN_RD;
          state_next = ST_SCHK;
        end
      end
      ST_SCHK: begin
        if (sts.hit) begin
          cmd.op     = CMD_HIT;
          state_next = sts.act_alloc ? ST_AHIT : ST_FHIT;
        end else begin
          cmd.op     = CMD_SCAN_NEXT;
          state_next = ST_SRD;
        end
      end
      // allocate from a fitting segment, split off the excess
      ST_AHIT: begin
        if (sts.split && sts.seg_full) begin
          cmd.op     = CMD_FAIL;
          cmd.code   = STAT_TABLE_FULL;
          state_next = ST_FINISH;
        end else begin
          cmd.op     = CMD_GRANT;
          state_next = sts.split ? ST_UPCHK : ST_FINISH;
        end
      end
      ST_UPCHK: begin
        if (sts.up_more) begin
          cmd.op     = CMD_UP_RD;
          state_next = ST_UPWR;
        end else begin
          cmd.op     = CMD_INSERT;
          state_next = ST_FINISH;
        end
      end
      ST_UPWR: begin
        cmd.op     = CMD_UP_WR;
        state_next = ST_UPCHK;
      end
      // free with merge of free neighbors
      ST_FHIT: begin
        if (sts.nx_exists) begin
          cmd.op     = CMD_NX_RD;
          state_next = ST_NXCHK;
        end else begin
          state_next = ST_FWR;
        end
      end
      ST_NXCHK: begin
        cmd.op     = CMD_NX_CHK;
        state_next = ST_FWR;
      end
      ST_FWR: begin
        cmd.op     = CMD_FREE_WR;
        state_next = ST_DNCHK;
      end
      ST_DNCHK: begin
        if (sts.dn_more) begin
          cmd.op     = CMD_DN_RD;
          state_next = ST_DNWR;
        end else begin
          cmd.op     = CMD_DN_FIN;
          state_next = ST_FINISH;
        end
      end
      ST_DNWR: begin
        cmd.op     = CMD_DN_WR;
        state_next = ST_DNCHK;
      end
      // nothing fits: try to open a new slab
      ST_MISS: begin
        if (sts.pool_full) begin
          cmd.op     = CMD_FAIL;
          cmd.code   = STAT_NO_SPACE;
          state_next = ST_FINISH;
        end else begin
          cmd.op     = CMD_NSS;
          state_next = ST_OPEN;
        end
      end
      ST_OPEN: begin
        if (sts.new_too_big) begin
          cmd.op     = CMD_FAIL;
          cmd.code   = STAT_NO_SPACE;
          state_next = ST_FINISH;
        end else if (sts.no_slot) begin
          cmd.op     = CMD_FAIL;
          cmd.code   = STAT_TABLE_FULL;
          state_next = ST_FINISH;
        end else begin
          cmd.op     = CMD_OPEN;
          state_next = sts.open_excess ? ST_OREST : ST_FINISH;
        end
      end
      ST_OREST: begin
        cmd.op     = CMD_OPEN_REST;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts.out_busy) begin
          cmd.op     = CMD_FINISH;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end
endmodule

`default_nettype wire

### hw/rtl/pslab_dp.sv
// ---------------------------------------------------------------------------
// pslab_dp
// Datapath: configuration, page divider, segment table, slab counters and
// the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pslab_dp #(
  parameter int MAX_SLABS     = 8,
  parameter int SEGS_PER_SLAB = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [pslab_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [pslab_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic [pslab_pkg::ACT_W-1:0]           req_action,
  input  wire logic [pslab_pkg::BYTES_W-1:0]         req_bytes,
  input  wire logic [pslab_pkg::TSLAB_W-1:0]         req_target_slab,
  input  wire logic [pslab_pkg::PAGE_W-1:0]          req_target_page,
  input  wire pslab_pkg::dp_cmd_t                    cmd,
  output      pslab_pkg::dp_status_t                 sts,
  input  wire logic                                  rsp_ready,
  output      logic                                  rsp_valid,
  output      logic [pslab_pkg::STAT_W-1:0]          rsp_status,
  output      logic [pslab_pkg::TSLAB_W-1:0]         rsp_slab,
  output      logic [pslab_pkg::PAGE_W-1:0]          rsp_start,
  output      logic [pslab_pkg::PAGE_W-1:0]          rsp_pages,
  output      logic [pslab_pkg::PAGE_W-1:0]          rsp_pool_used
);
  import pslab_pkg::*;

  localparam int SLAB_W    = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
  localparam int OPEN_W    = $clog2(MAX_SLABS + 1);
  localparam int CNT_W     = $clog2(SEGS_PER_SLAB + 1);
  localparam int DEPTH     = MAX_SLABS * SEGS_PER_SLAB;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int DIV_CNT_W = $clog2(BYTES_W + 1);

  function automatic logic [ADDR_W-1:0] seg_addr(input logic [OPEN_W-1:0] sl,
                                                 input logic [CNT_W-1:0]  ix);
    return ADDR_W'(sl) * ADDR_W'(SEGS_PER_SLAB) + ADDR_W'(ix);
  endfunction

  // configuration and slab bookkeeping
  logic [PB_W-1:0]   page_bytes;
  logic [PAGE_W-1:0] pool_max;
  logic [PAGE_W-1:0] slab_max;
  logic [PAGE_W-1:0] nss;
  logic [PAGE_W-1:0] pages_in;
  logic [OPEN_W-1:0] open_cnt;
  logic [CNT_W-1:0]  seg_cnt [MAX_SLABS];

  // per-item working registers
  logic [ACT_W-1:0]   act;
  logic [TSLAB_W-1:0] tslab;
  logic [PAGE_W-1:0]  tpage;
  logic [BYTES_W-1:0] quo;
  logic [PB_W-1:0]    rem;
  logic [DIV_CNT_W-1:0] dcnt;
  logic [OPEN_W-1:0]  s;
  logic [CNT_W-1:0]   k;
  logic [CNT_W-1:0]   src;
  seg_entry_t         cur;
  seg_entry_t         prev;
  logic               mp;
  logic               mn;
  logic [PAGE_W-1:0]  nx_len;
  logic [1:0]         dshift;
  logic [STAT_W-1:0]  res_status;
  logic [TSLAB_W-1:0] res_slab;
  logic [PAGE_W-1:0]  res_start;
  logic [PAGE_W-1:0]  res_pages;

  // combinational helpers
  logic [PB_W-1:0]    divisor;
  logic [PB_W:0]      trial;
  logic               trial_ge;
  logic [BYTES_W:0]   want;
  logic [PAGE_W-1:0]  pages;
  logic [CNT_W-1:0]   cur_cnt;
  logic [CNT_W-1:0]   kp1;
  logic [PAGE_W-1:0]  pool_left;
  logic [PAGE_W-1:0]  m_len;
  seg_entry_t         rdata;
  logic [$bits(seg_entry_t)-1:0] ram_rdata;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ADDR_W-1:0]  ram_raddr;
  seg_entry_t         ram_wdata;

  // restoring divider step and rounded-up page count
  assign divisor  = (page_bytes == '0) ? PB_W'(1) : page_bytes;
  assign trial    = {rem, quo[BYTES_W-1]};
  assign trial_ge = trial >= {1'b0, divisor};
  assign want     = {1'b0, quo} + {{BYTES_W{1'b0}}, |rem};
  assign pages    = want[PAGE_W-1:0];

  assign cur_cnt   = seg_cnt[s[SLAB_W-1:0]];
  assign kp1       = k + CNT_W'(1);
  assign pool_left = pool_max - pages_in;
  assign rdata     = seg_entry_t'(ram_rdata);
  assign m_len     = cur.len + (mp ? prev.len : '0) + (mn ? nx_len : '0);

  // status to the sequencer
  always_comb begin
    sts.act_alloc   = act == ACT_ALLOC;
    sts.act_free    = act == ACT_FREE;
    sts.act_clear   = act == ACT_CLEAR;
    sts.tslab_bad   = {5'd0, tslab} >= 8'(open_cnt);
    sts.div_done    = dcnt == DIV_CNT_W'(BYTES_W);
    sts.req_too_big = want > (BYTES_W + 1)'(slab_max);
    sts.scan_end    = (act == ACT_ALLOC) ? (s >= open_cnt) : (k >= cur_cnt);
    sts.hit         = (act == ACT_ALLOC) ? (!rdata.used && rdata.len >= pages)
                                         : (rdata.used && rdata.start == tpage);
    sts.split       = cur.len != pages;
    sts.seg_full    = cur_cnt >= CNT_W'(SEGS_PER_SLAB);
    sts.up_more     = src > kp1;
    sts.nx_exists   = kp1 < cur_cnt;
    sts.dn_more     = (dshift != 2'd0) && (src < cur_cnt);
    sts.pool_full   = pages_in >= pool_max;
    sts.new_too_big = pages > nss;
    sts.no_slot     = open_cnt >= OPEN_W'(MAX_SLABS);
    sts.open_excess = nss != pages;
    sts.out_busy    = rsp_valid && !rsp_ready;
  end

  // segment table addressing
  always_comb begin
    ram_raddr = seg_addr(s, k);
    ram_we    = 1'b0;
    ram_waddr = seg_addr(s, k);
    ram_wdata = cur;
    case (cmd.op)
      CMD_UP_RD: ram_raddr = seg_addr(s, src - CNT_W'(1));
      CMD_NX_RD: ram_raddr = seg_addr(s, kp1);
      CMD_DN_RD: ram_raddr = seg_addr(s, src);
      CMD_GRANT: begin
        ram_we    = 1'b1;
        ram_wdata = '{used: 1'b1, start: cur.start, len: pages};
      end
      CMD_UP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = seg_addr(s, src);
        ram_wdata = rdata;
      end
      CMD_INSERT: begin
        ram_we    = 1'b1;
        ram_waddr = seg_addr(s, kp1);
        ram_wdata = '{used: 1'b0, start: cur.start + pages, len: cur.len - pages};
      end
      CMD_FREE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = seg_addr(s, k - CNT_W'(mp));
        ram_wdata = '{used: 1'b0, start: (mp ? prev.start : cur.start), len: m_len};
      end
      CMD_DN_WR: begin
        ram_we    = 1'b1;
        ram_waddr = seg_addr(s, src - CNT_W'(dshift));
        ram_wdata = rdata;
      end
      CMD_OPEN: begin
        ram_we    = 1'b1;
        ram_waddr = seg_addr(open_cnt, '0);
        ram_wdata = '{used: 1'b1, start: '0, len: pages};
      end
      CMD_OPEN_REST: begin
        ram_we    = 1'b1;
        ram_waddr = seg_addr(s, CNT_W'(1));
        ram_wdata = '{used: 1'b0, start: pages, len: nss - pages};
      end
      default: begin
      end
    endcase
  end

  pslab_ram #(
    .WIDTH ($bits(seg_entry_t)),
    .DEPTH (DEPTH)
  ) u_seg_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // configuration, slab counters and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      page_bytes <= PAGE_BYTES_RST;
      pool_max   <= POOL_MAX_RST;
      slab_max   <= SLAB_MAX_RST;
      nss        <= SLAB_MAX_RST;
      pages_in   <= '0;
      open_cnt   <= '0;
      rsp_valid  <= 1'b0;
      for (int i = 0; i < MAX_SLABS; i++) begin
        seg_cnt[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PAGE_BYTES: page_bytes <= cfg_data;
          CFG_POOL_MAX:   pool_max   <= cfg_data[PAGE_W-1:0];
          CFG_SLAB_MAX: begin
            slab_max <= cfg_data[PAGE_W-1:0];
            nss      <= cfg_data[PAGE_W-1:0];
          end
          default: begin
          end
        endcase
      end
      // result valid: set when an item finishes, cleared when taken
      if (cmd.op == CMD_FINISH) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (cmd.op)
        CMD_CLEAR: begin
          open_cnt <= '0;
          pages_in <= '0;
          nss      <= slab_max;
          for (int i = 0; i < MAX_SLABS; i++) begin
            seg_cnt[i] <= '0;
          end
        end
        CMD_NSS: begin
          if (pool_left < nss) begin
            nss <= pool_left;
          end
        end
        CMD_OPEN: begin
          seg_cnt[open_cnt[SLAB_W-1:0]] <= (nss != pages) ? CNT_W'(2) : CNT_W'(1);
          open_cnt <= open_cnt + OPEN_W'(1);
          pages_in <= pages_in + nss;
        end
        CMD_INSERT: seg_cnt[s[SLAB_W-1:0]] <= cur_cnt + CNT_W'(1);
        CMD_DN_FIN: seg_cnt[s[SLAB_W-1:0]] <= cur_cnt - CNT_W'(dshift);
        default: begin
        end
      endcase
    end
  end

  // per-item working registers and result payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_LOAD: begin
        act        <= req_action;
        tslab      <= req_target_slab;
        tpage      <= req_target_page;
        quo        <= req_bytes;
        rem        <= '0;
        dcnt       <= '0;
        k          <= '0;
        s          <= (req_action == ACT_FREE) ? OPEN_W'(req_target_slab) : '0;
        res_status <= STAT_OK;
        res_slab   <= '0;
        res_start  <= '0;
        res_pages  <= '0;
      end
      CMD_DIV_STEP: begin
        if (trial_ge) begin
          rem <= PB_W'(trial - {1'b0, divisor});
        end else begin
          rem <= trial[PB_W-1:0];
        end
        quo  <= {quo[BYTES_W-2:0], trial_ge};
        dcnt <= dcnt + DIV_CNT_W'(1);
      end
      CMD_SCAN_NEXT: begin
        prev <= rdata;
        if ((act == ACT_ALLOC) && (kp1 >= cur_cnt)) begin
          s <= s + OPEN_W'(1);
          k <= '0;
        end else begin
          k <= kp1;
        end
      end
      CMD_HIT: begin
        cur <= rdata;
        mn  <= 1'b0;
        mp  <= (k != '0) && !prev.used;
      end
      CMD_GRANT: begin
        res_slab  <= TSLAB_W'(s);
        res_start <= cur.start;
        res_pages <= pages;
        src       <= cur_cnt;
      end
      CMD_UP_WR: src <= src - CNT_W'(1);
      CMD_NX_CHK: begin
        mn     <= !rdata.used;
        nx_len <= rdata.len;
      end
      CMD_FREE_WR: begin
        dshift <= {1'b0, mp} + {1'b0, mn};
        src    <= kp1 + CNT_W'(mn);
      end
      CMD_DN_WR: src <= src + CNT_W'(1);
      CMD_OPEN: begin
        s         <= open_cnt;
        res_slab  <= TSLAB_W'(open_cnt);
        res_start <= '0;
        res_pages <= pages;
      end
      CMD_FAIL: res_status <= cmd.code;
      CMD_FINISH: begin
        rsp_status    <= res_status;
        rsp_slab      <= res_slab;
        rsp_start     <= res_start;
        rsp_pages     <= res_pages;
        rsp_pool_used <= pages_in;
      end
      default: begin
      end
    endcase
  end
endmodule

`default_nettype wire

### hw/rtl/page_slab_first_fit_allocator_top.sv
// Page slab first-fit allocator. Takes one request item at a time and returns
// one result item per request. An allocate first rounds bytes up to pages
// (one quotient bit per cycle), then reads each segment entry it visits
// across the open slabs, and moves entries up when a split inserts a new free
// segment; a free reads each entry it visits in its slab and moves entries
// down after a merge. The segment table, which has one read and one write
// port with registered read, serves every visit and every move. A new request
// is taken while the previous result still waits on the response channel.
// ---------------------------------------------------------------------------
// page_slab_first_fit_allocator_top
// Top level: sequencer, datapath, request/response channels, config port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module page_slab_first_fit_allocator_top #(
  parameter int MAX_SLABS     = 8,
  parameter int SEGS_PER_SLAB = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  pslab_req_if.sink                             req,
  pslab_rsp_if.source                           rsp,
  input  wire logic                             cfg_we,
  input  wire logic [pslab_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pslab_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pslab_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t sts;

  // sequencer
  pslab_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath with segment table
  pslab_dp #(
    .MAX_SLABS     (MAX_SLABS),
    .SEGS_PER_SLAB (SEGS_PER_SLAB)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .req_action      (req.action),
    .req_bytes       (req.request_bytes),
    .req_target_slab (req.target_slab),
    .req_target_page (req.target_start_page),
    .cmd             (cmd),
    .sts             (sts),
    .rsp_ready       (rsp.ready),
    .rsp_valid       (rsp.valid),
    .rsp_status      (rsp.status),
    .rsp_slab        (rsp.grant_slab),
    .rsp_start       (rsp.grant_start_page),
    .rsp_pages       (rsp.grant_pages),
    .rsp_pool_used   (rsp.pool_pages_used)
  );
endmodule

`default_nettype wire

### hw/rtl/pslab_checker.sv
// ---------------------------------------------------------------------------
// pslab_props
// Port-level checks of the allocator, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pslab_props (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             req_valid,
  input wire logic                             req_ready,
  input wire logic                             rsp_valid,
  input wire logic                             rsp_ready,
  input wire logic [pslab_pkg::STAT_W-1:0]     rsp_status,
  input wire logic [pslab_pkg::TSLAB_W-1:0]    rsp_grant_slab,
  input wire logic [pslab_pkg::PAGE_W-1:0]     rsp_grant_start_page,
  input wire logic [pslab_pkg::PAGE_W-1:0]     rsp_grant_pages
);
  import pslab_pkg::*;

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
                                $stable(rsp_grant_pages))
    else $error("stalled result changed");

  // one item in flight: ready drops after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  // status code range
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_status == STAT_OK || rsp_status == STAT_TOO_BIG ||
                   rsp_status == STAT_NO_SPACE || rsp_status == STAT_FREE_UNKNOWN ||
                   rsp_status == STAT_TABLE_FULL))
    else $error("bad status code");

  // grant fields zero on failure
  a_fail_no_grant: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != STAT_OK |-> rsp_grant_pages == '0 &&
                                           rsp_grant_slab == '0 &&
                                           rsp_grant_start_page == '0)
    else $error("grant on failed request");
endmodule

bind page_slab_first_fit_allocator_top pslab_props u_pslab_props (
  .clk                  (clk),
  .rst                  (rst),
  .req_valid            (req.valid),
  .req_ready            (req.ready),
  .rsp_valid            (rsp.valid),
  .rsp_ready            (rsp.ready),
  .rsp_status           (rsp.status),
  .rsp_grant_slab       (rsp.grant_slab),
  .rsp_grant_start_page (rsp.grant_start_page),
  .rsp_grant_pages      (rsp.grant_pages)
);

`default_nettype wire

### dv/pslab_checker.sv
// ---------------------------------------------------------------------------
// pslab_checker
// Watches the request, response and config ports of the page slab allocator.
// Keeps its own copy of slab and segment state, works out the result of each
// accepted request item and compares it field by field with the response.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pslab_checker
  import pslab_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  pslab_req_if                  req,
  pslab_rsp_if                  rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending
);

  localparam int NSLABS = 8;
  localparam int NSEGS  = 32;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [TSLAB_W-1:0] gslab;
    logic [PAGE_W-1:0]  gstart;
    logic [PAGE_W-1:0]  gpages;
    logic [PAGE_W-1:0]  used_pages;
  } alloc_result_t;

  // shadow configuration
  logic [PB_W-1:0]   page_bytes;
  logic [PAGE_W-1:0] pool_max;
  logic [PAGE_W-1:0] slab_max;

  // shadow slab state
  logic [PAGE_W-1:0] seg_start [NSLABS][NSEGS];
  logic [PAGE_W-1:0] seg_len   [NSLABS][NSEGS];
  logic              seg_used  [NSLABS][NSEGS];
  int                seg_cnt   [NSLABS];
  int                open_slabs;
  int                slab_pages;
  int                next_size;

  alloc_result_t expected_results[$];

  assign pending = expected_results.size();

  function automatic void seg_insert(int s, int pos, int st, int len);
    for (int k = seg_cnt[s]; k > pos; k--) begin
      seg_start[s][k] = seg_start[s][k-1];
      seg_len[s][k]   = seg_len[s][k-1];
      seg_used[s][k]  = seg_used[s][k-1];
    end
    seg_start[s][pos] = st[15:0];
    seg_len[s][pos]   = len[15:0];
    seg_used[s][pos]  = 1'b0;
    seg_cnt[s]++;
  endfunction

  function automatic void seg_remove(int s, int pos);
    for (int k = pos; k + 1 < seg_cnt[s]; k++) begin
      seg_start[s][k] = seg_start[s][k+1];
      seg_len[s][k]   = seg_len[s][k+1];
      seg_used[s][k]  = seg_used[s][k+1];
    end
    seg_cnt[s]--;
  endfunction

  // 0 granted, 1 nothing fits, 2 split needed but slab table full
  function automatic int fit_slab(int s, int pages, output int st);
    int excess;
    st = 0;
    for (int k = 0; k < seg_cnt[s]; k++) begin
      if (!seg_used[s][k] && int'(seg_len[s][k]) >= pages) begin
        excess = int'(seg_len[s][k]) - pages;
        st = seg_start[s][k];
        if (excess > 0 && seg_cnt[s] >= NSEGS) return 2;
        seg_len[s][k]  = pages[15:0];
        seg_used[s][k] = 1'b1;
        if (excess > 0) seg_insert(s, k + 1, st + pages, excess);
        return 0;
      end
    end
    return 1;
  endfunction

  function automatic void predict_alloc(logic [31:0] bytes, ref alloc_result_t r);
    longint ps, want;
    int pages, st, fit;
    ps = (page_bytes == 0) ? 1 : longint'(page_bytes);
    want = (longint'(bytes) + ps - 1) / ps;
    if (want > longint'(slab_max)) begin
      r.status = STAT_TOO_BIG;
      return;
    end
    pages = int'(want);
    for (int s = 0; s < open_slabs; s++) begin
      fit = fit_slab(s, pages, st);
      if (fit == 0) begin
        r.gslab = s[2:0]; r.gstart = st[15:0]; r.gpages = pages[15:0];
        return;
      end
      if (fit == 2) begin
        r.status = STAT_TABLE_FULL;
        return;
      end
    end
    if (slab_pages >= int'(pool_max)) begin
      r.status = STAT_NO_SPACE;
      return;
    end
    if (int'(pool_max) - slab_pages < next_size) next_size = int'(pool_max) - slab_pages;
    if (pages > next_size) begin
      r.status = STAT_NO_SPACE;
      return;
    end
    if (open_slabs >= NSLABS) begin
      r.status = STAT_TABLE_FULL;
      return;
    end
    seg_cnt[open_slabs] = 0;
    seg_insert(open_slabs, 0, 0, next_size);
    open_slabs++;
    slab_pages += next_size;
    fit = fit_slab(open_slabs - 1, pages, st);
    r.gslab = 3'(open_slabs - 1); r.gstart = st[15:0]; r.gpages = pages[15:0];
  endfunction

  function automatic logic [STAT_W-1:0] predict_free(int s, logic [PAGE_W-1:0] pg);
    int j;
    if (s >= open_slabs) return STAT_FREE_UNKNOWN;
    for (j = 0; j < seg_cnt[s]; j++)
      if (seg_used[s][j] && seg_start[s][j] == pg) break;
    if (j >= seg_cnt[s]) return STAT_FREE_UNKNOWN;
    // merge with a free neighbor on the left, then on the right
    if (j > 0 && !seg_used[s][j-1]) begin
      seg_start[s][j] = seg_start[s][j-1];
      seg_len[s][j]   = seg_len[s][j] + seg_len[s][j-1];
      seg_remove(s, j - 1);
      j--;
    end
    if (j + 1 < seg_cnt[s] && !seg_used[s][j+1]) begin
      seg_len[s][j] = seg_len[s][j] + seg_len[s][j+1];
      seg_remove(s, j + 1);
    end
    seg_used[s][j] = 1'b0;
    return STAT_OK;
  endfunction

  function automatic void clear_slabs();
    foreach (seg_cnt[i]) seg_cnt[i] = 0;
    open_slabs = 0;
    slab_pages = 0;
    next_size  = int'(slab_max);
  endfunction

  function automatic alloc_result_t predict_item(logic [ACT_W-1:0] act, logic [31:0] bytes,
                                                 logic [2:0] ts, logic [PAGE_W-1:0] tp);
    alloc_result_t r;
    r = '0;
    case (act)
      ACT_ALLOC: predict_alloc(bytes, r);
      ACT_FREE:  r.status = predict_free(int'(ts), tp);
      ACT_CLEAR: clear_slabs();
      default: ;
    endcase
    r.used_pages = slab_pages[15:0];
    return r;
  endfunction

  // watch config, requests and responses
  always @(posedge clk) begin
    alloc_result_t exp_r, act_r;
    if (rst) begin
      page_bytes = PAGE_BYTES_RST;
      pool_max   = POOL_MAX_RST;
      slab_max   = SLAB_MAX_RST;
      for (int s = 0; s < NSLABS; s++) seg_cnt[s] = 0;
      open_slabs = 0;
      slab_pages = 0;
      next_size  = int'(SLAB_MAX_RST);
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PAGE_BYTES: page_bytes = cfg_data;
          CFG_POOL_MAX:   pool_max = cfg_data[15:0];
          CFG_SLAB_MAX: begin
            slab_max  = cfg_data[15:0];
            next_size = int'(cfg_data[15:0]);
          end
          default: ;
        endcase
      end
      if (req.valid && req.ready)
        expected_results = {expected_results,
                            predict_item(req.action, req.request_bytes,
                                         req.target_slab, req.target_start_page)};
      if (rsp.valid && rsp.ready) begin
        act_r = '{rsp.status, rsp.grant_slab, rsp.grant_start_page, rsp.grant_pages,
                  rsp.pool_pages_used};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result item status=%0d", $time, rsp.status);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.status != act_r.status) begin
            $display("%0t: status exp %0d got %0d", $time, exp_r.status, act_r.status);
            errors++;
          end
          if (exp_r.gslab != act_r.gslab) begin
            $display("%0t: grant_slab exp %0d got %0d", $time, exp_r.gslab, act_r.gslab);
            errors++;
          end
          if (exp_r.gstart != act_r.gstart) begin
            $display("%0t: grant_start_page exp %0d got %0d", $time, exp_r.gstart,
                     act_r.gstart);
            errors++;
          end
          if (exp_r.gpages != act_r.gpages) begin
            $display("%0t: grant_pages exp %0d got %0d", $time, exp_r.gpages, act_r.gpages);
            errors++;
          end
          if (exp_r.used_pages != act_r.used_pages) begin
            $display("%0t: pool_pages_used exp %0d got %0d", $time, exp_r.used_pages,
                     act_r.used_pages);
            errors++;
          end
        end
      end
    end
  end

  initial errors = 0;

endmodule

### dv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the page slab first-fit allocator. Runs a directed
// set of corner requests, then random allocate, free, clear and no-op traffic over
// several configurations and idle patterns; checking lives in pslab_checker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import pslab_pkg::*;

  localparam longint CYCLE_LIMIT = 4000000;
  localparam int     DRAIN_CYCLES = 1200;

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int   errors, pending;
  int   idle_mode;
  longint cycles;

  // page config of the running phase, for sizing requests
  longint cur_pb, cur_slab;

  // blocks granted and not yet freed, plus actions awaiting a result
  logic [18:0]      live_blocks[$];
  logic [ACT_W-1:0] sent_actions[$];

  pslab_req_if req();
  pslab_rsp_if rsp();

  page_slab_first_fit_allocator_top i_dut (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pslab_checker i_checker (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // response stall per idle mode
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      case (idle_mode)
        2: rsp.ready <= ($urandom_range(0, 99) >= 60);
        3: rsp.ready <= ($urandom_range(0, 99) >= 8);
        default: rsp.ready <= 1'b1;
      endcase
    end
  end

  // track grants so frees mostly hit real blocks
  always @(posedge clk) begin
    logic [ACT_W-1:0] a;
    if (!rst) begin
      if (req.valid && req.ready) sent_actions = {sent_actions, req.action};
      if (rsp.valid && rsp.ready && sent_actions.size() > 0) begin
        a = sent_actions.pop_front();
        if (a == ACT_ALLOC && rsp.status == STAT_OK)
          live_blocks = {live_blocks, {rsp.grant_slab, rsp.grant_start_page}};
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_item(logic [ACT_W-1:0] act, logic [31:0] bytes, logic [2:0] ts,
                           logic [PAGE_W-1:0] tp);
    int gap;
    gap = 0;
    if (idle_mode == 1 && $urandom_range(0, 99) < 60) gap = $urandom_range(1, 6);
    if (idle_mode == 3 && $urandom_range(0, 99) < 8) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid             <= 1'b1;
    req.action            <= act;
    req.request_bytes     <= bytes;
    req.target_slab       <= ts;
    req.target_start_page <= tp;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic drain_and_idle();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(longint pb, longint pool, longint slab);
    cfg_we <= 1'b1; cfg_index <= CFG_PAGE_BYTES; cfg_data <= pb[16:0];
    @(posedge clk);
    cfg_index <= CFG_POOL_MAX; cfg_data <= pool[16:0];
    @(posedge clk);
    cfg_index <= CFG_SLAB_MAX; cfg_data <= slab[16:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_pb   = (pb == 0) ? 1 : pb;
    cur_slab = slab;
  endtask

  // bytes for a request of a chosen page count, often off a page boundary
  function automatic logic [31:0] bytes_for(longint pages);
    longint b;
    b = pages * cur_pb - $urandom_range(0, int'(cur_pb - 1));
    if (b < 0) b = 0;
    if (b > 64'hFFFF_FFFF) b = 64'hFFFF_FFFF;
    return b[31:0];
  endfunction

  task automatic random_item();
    int r, k;
    longint p;
    logic [18:0] blk;
    r = $urandom_range(0, 99);
    if (r >= 55 && r < 88 && live_blocks.size() > 0) begin
      k = $urandom_range(0, live_blocks.size() - 1);
      blk = live_blocks[k];
      live_blocks.delete(k);
      send_item(ACT_FREE, $urandom, blk[18:16], blk[15:0]);
    end else if (r >= 88 && r < 93) begin
      send_item(ACT_FREE, $urandom, 3'($urandom), 16'($urandom));
    end else if (r >= 93 && r < 95) begin
      live_blocks.delete();
      send_item(ACT_CLEAR, $urandom, 3'($urandom), 16'($urandom));
    end else if (r >= 95 && r < 97) begin
      send_item(ACT_NONE, $urandom, 3'($urandom), 16'($urandom));
    end else if (r >= 97) begin
      send_item(ACT_ALLOC, $urandom, 3'($urandom), 16'($urandom));
    end else begin
      if ($urandom_range(0, 1) == 0)
        p = $urandom_range(0, int'((cur_slab < 8) ? cur_slab : 8));
      else
        p = $urandom_range(0, int'(cur_slab + 1));
      send_item(ACT_ALLOC, bytes_for(p), 3'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    longint cfg_pb[6]   = '{16, 0, 65536, 1, 100, 4};
    longint cfg_pool[6] = '{200, 1, 65535, 300, 65535, 90};
    longint cfg_slab[6] = '{64, 1, 65535, 40, 4, 65535};
    rst = 1'b1;
    cycles = 0;
    idle_mode = 0;
    cfg_we <= 1'b0; cfg_index <= CFG_PAGE_BYTES; cfg_data <= '0;
    req.valid <= 1'b0; req.action <= ACT_NONE; req.request_bytes <= '0;
    req.target_slab <= '0; req.target_start_page <= '0;
    cur_pb = 512; cur_slab = 8192;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners under the reset configuration
    send_item(ACT_ALLOC, 32'd0, 3'd0, 16'd0);
    send_item(ACT_ALLOC, 32'd1, 3'd0, 16'd0);
    send_item(ACT_ALLOC, 32'hFFFF_FFFF, 3'd7, 16'hFFFF);
    send_item(ACT_ALLOC, 32'd4194304, 3'd0, 16'd0);
    send_item(ACT_ALLOC, 32'd4194305, 3'd0, 16'd0);
    send_item(ACT_ALLOC, 32'd513, 3'd0, 16'd0);
    send_item(ACT_FREE, 32'd0, 3'd7, 16'd0);
    send_item(ACT_FREE, 32'd0, 3'd0, 16'hFFFF);
    send_item(ACT_FREE, 32'd0, 3'd0, 16'd0);
    send_item(ACT_FREE, 32'd0, 3'd0, 16'd0);
    send_item(ACT_FREE, 32'd0, 3'd0, 16'd1);
    send_item(ACT_FREE, 32'd0, 3'd1, 16'd0);
    send_item(ACT_NONE, 32'hFFFF_FFFF, 3'd7, 16'hFFFF);
    send_item(ACT_CLEAR, 32'd0, 3'd0, 16'd0);
    send_item(ACT_FREE, 32'd0, 3'd0, 16'd0);
    send_item(ACT_ALLOC, 32'd512, 3'd0, 16'd0);
    send_item(ACT_CLEAR, 32'd0, 3'd0, 16'd0);
    drain_and_idle();

    // random phases over several configurations and idle patterns
    for (int ph = 0; ph < 6; ph++) begin
      write_config(cfg_pb[ph], cfg_pool[ph], cfg_slab[ph]);
      live_blocks.delete();
      send_item(ACT_CLEAR, 32'd0, 3'd0, 16'd0);
      for (int m = 0; m < 4; m++) begin
        idle_mode = m;
        repeat (75) random_item();
      end
      drain_and_idle();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
